### rtl/core/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants, types, microcode table and arithmetic helpers for the
// open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int TABLE_SIZE = 11;
  localparam int KEY_W      = 31;
  localparam int FUNC_W     = 2;
  localparam int MODE_W     = 2;
  localparam int OUTCOME_W  = 2;
  localparam int SLOT_OUT_W = 4;
  localparam int MARK_W     = 2;

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int DIGITS = (KEY_W + 3) / 4;
  localparam int DIG_W  = $clog2(DIGITS);
  localparam int CNT_W  = (IDX_W > DIG_W) ? IDX_W : DIG_W;
  localparam int UPC_W  = 4;

  typedef logic [IDX_W-1:0] slot_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [UPC_W-1:0] upc_t;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;

  localparam logic [MODE_W-1:0] PM_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] PM_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] PM_DOUBLE = 2'd2;

  localparam logic [MARK_W-1:0] MK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MK_OCC   = 2'd1;
  localparam logic [MARK_W-1:0] MK_DEL   = 2'd2;

  localparam logic [OUTCOME_W-1:0] RES_OK       = 2'd0;
  localparam logic [OUTCOME_W-1:0] RES_DUP      = 2'd1;
  localparam logic [OUTCOME_W-1:0] RES_FULL     = 2'd2;
  localparam logic [OUTCOME_W-1:0] RES_NOTFOUND = 2'd3;

  // modulus values and quadratic step deltas, already reduced
  localparam logic [IDX_W:0] MOD_N    = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W:0] MOD_N1   = (IDX_W+1)'(TABLE_SIZE - 1);
  localparam slot_t          ONE_SLOT = slot_t'(1);
  localparam slot_t          FOUR_MOD = slot_t'(4 % TABLE_SIZE);
  localparam slot_t          SIX_MOD  = slot_t'(6 % TABLE_SIZE);

  // microprogram addresses
  localparam upc_t UPC_IDLE      = 4'd0;
  localparam upc_t UPC_MOD       = 4'd1;
  localparam upc_t UPC_DISPATCH  = 4'd2;
  localparam upc_t UPC_SCAN_INIT = 4'd3;
  localparam upc_t UPC_SCAN_RD   = 4'd4;
  localparam upc_t UPC_SCAN_CHK  = 4'd5;
  localparam upc_t UPC_INS_INIT  = 4'd6;
  localparam upc_t UPC_INS_PROBE = 4'd7;
  localparam upc_t UPC_INS_WR    = 4'd8;
  localparam upc_t UPC_LK_INIT   = 4'd9;
  localparam upc_t UPC_LK_RD     = 4'd10;
  localparam upc_t UPC_LK_CHK    = 4'd11;
  localparam upc_t UPC_FOUND     = 4'd12;
  localparam upc_t UPC_NOTFOUND  = 4'd13;
  localparam upc_t UPC_DUP       = 4'd14;
  localparam upc_t UPC_FULL      = 4'd15;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_MOD_DIGIT,
    ACT_SCAN_INIT,
    ACT_PROBE_INIT,
    ACT_WRITE_KEY,
    ACT_MARK_DEL
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_START,
    C_DIG_LAST,
    C_FUNC_BAD,
    C_IS_INSERT,
    C_MATCH,
    C_LAST,
    C_FREE,
    C_STOP
  } cond_t;

  typedef struct packed {
    act_t                 act;
    logic                 adv;
    logic                 emit;
    logic [OUTCOME_W-1:0] res;
    cond_t                cond_a;
    upc_t                 tgt_a;
    cond_t                cond_b;
    upc_t                 tgt_b;
    upc_t                 tgt_n;
  } ucode_t;

  typedef struct packed {
    act_t                 act;
    logic                 adv;
    logic                 emit;
    logic [OUTCOME_W-1:0] res;
  } ctrl_t;

  typedef struct packed {
    logic dig_last;
    logic func_bad;
    logic is_insert;
    logic match;
    logic last;
    logic free;
    logic stop;
  } stat_t;

  function automatic ucode_t uword(input act_t act, input logic adv, input logic emit,
                                   input logic [OUTCOME_W-1:0] res,
                                   input cond_t ca, input upc_t ta,
                                   input cond_t cb, input upc_t tb, input upc_t tn);
    ucode_t w;
    w.act    = act;
    w.adv    = adv;
    w.emit   = emit;
    w.res    = res;
    w.cond_a = ca;
    w.tgt_a  = ta;
    w.cond_b = cb;
    w.tgt_b  = tb;
    w.tgt_n  = tn;
    return w;
  endfunction

  // control store: jump a has priority over jump b, else go to tgt_n
  function automatic ucode_t ucode_rom(input upc_t a);
    ucode_t w;
    case (a)
      UPC_IDLE:      w = uword(ACT_LOAD, 1'b0, 1'b0, RES_OK,
                               C_START, UPC_MOD, C_NEVER, UPC_IDLE, UPC_IDLE);
      UPC_MOD:       w = uword(ACT_MOD_DIGIT, 1'b0, 1'b0, RES_OK,
                               C_DIG_LAST, UPC_DISPATCH, C_NEVER, UPC_IDLE, UPC_MOD);
      UPC_DISPATCH:  w = uword(ACT_NONE, 1'b0, 1'b0, RES_OK,
                               C_FUNC_BAD, UPC_NOTFOUND, C_IS_INSERT, UPC_SCAN_INIT,
                               UPC_LK_INIT);
      UPC_SCAN_INIT: w = uword(ACT_SCAN_INIT, 1'b0, 1'b0, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_SCAN_RD);
      UPC_SCAN_RD:   w = uword(ACT_NONE, 1'b0, 1'b0, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_SCAN_CHK);
      UPC_SCAN_CHK:  w = uword(ACT_NONE, 1'b1, 1'b0, RES_OK,
                               C_MATCH, UPC_DUP, C_LAST, UPC_INS_INIT, UPC_SCAN_RD);
      UPC_INS_INIT:  w = uword(ACT_PROBE_INIT, 1'b0, 1'b0, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_INS_PROBE);
      UPC_INS_PROBE: w = uword(ACT_NONE, 1'b1, 1'b0, RES_OK,
                               C_FREE, UPC_INS_WR, C_LAST, UPC_FULL, UPC_INS_PROBE);
      UPC_INS_WR:    w = uword(ACT_WRITE_KEY, 1'b0, 1'b1, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_IDLE);
      UPC_LK_INIT:   w = uword(ACT_PROBE_INIT, 1'b0, 1'b0, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_LK_RD);
      UPC_LK_RD:     w = uword(ACT_NONE, 1'b0, 1'b0, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_LK_CHK);
      UPC_LK_CHK:    w = uword(ACT_NONE, 1'b1, 1'b0, RES_OK,
                               C_MATCH, UPC_FOUND, C_STOP, UPC_NOTFOUND, UPC_LK_RD);
      UPC_FOUND:     w = uword(ACT_MARK_DEL, 1'b0, 1'b1, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_IDLE);
      UPC_NOTFOUND:  w = uword(ACT_NONE, 1'b0, 1'b1, RES_NOTFOUND,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_IDLE);
      UPC_DUP:       w = uword(ACT_NONE, 1'b0, 1'b1, RES_DUP,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_IDLE);
      UPC_FULL:      w = uword(ACT_NONE, 1'b0, 1'b1, RES_FULL,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_IDLE);
      default:       w = uword(ACT_NONE, 1'b0, 1'b0, RES_OK,
                               C_NEVER, UPC_IDLE, C_NEVER, UPC_IDLE, UPC_IDLE);
    endcase
    return w;
  endfunction

  // one hex digit of a running remainder: (r*16 + dig) mod m, with r < m
  function automatic slot_t mod_digit(input slot_t r, input logic [3:0] dig,
                                      input logic [IDX_W:0] m);
    logic [IDX_W+3:0] v;
    logic [IDX_W+3:0] km;
    logic [IDX_W+3:0] rem;
    v   = {r, dig};
    rem = v;
    for (int k = 1; k < 16; k++) begin
      km = (IDX_W+4)'(k) * (IDX_W+4)'(m);
      if (v >= km) rem = v - km;
    end
    return rem[IDX_W-1:0];
  endfunction

  // (a + b) mod TABLE_SIZE for a, b below TABLE_SIZE
  function automatic slot_t mod_add(input slot_t a, input slot_t b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_N) s = s - MOD_N;
    return s[IDX_W-1:0];
  endfunction

endpackage

### rtl/core/oaht_ram.sv
// ----------------------------------------------------------------------------
// oaht_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/oaht_useq.sv
// ----------------------------------------------------------------------------
// oaht_useq
// Microprogram sequencer: step counter, control store lookup and two-way
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module oaht_useq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  oaht_pkg::stat_t stat,
  output oaht_pkg::ctrl_t ctrl,
  output logic           busy
);
  import oaht_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  ucode_t word;
  logic   hit_a;
  logic   hit_b;

  function automatic logic cond_eval(input cond_t c, input stat_t s, input logic st);
    logic r;
    case (c)
      C_NEVER:     r = 1'b0;
      C_START:     r = st;
      C_DIG_LAST:  r = s.dig_last;
      C_FUNC_BAD:  r = s.func_bad;
      C_IS_INSERT: r = s.is_insert;
      C_MATCH:     r = s.match;
      C_LAST:      r = s.last;
      C_FREE:      r = s.free;
      C_STOP:      r = s.stop;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    word  = ucode_rom(upc_r);
    hit_a = cond_eval(word.cond_a, stat, start);
    hit_b = cond_eval(word.cond_b, stat, start);
    if (hit_a) begin
      upc_nxt = word.tgt_a;
    end else if (hit_b) begin
      upc_nxt = word.tgt_b;
    end else begin
      upc_nxt = word.tgt_n;
    end
    ctrl.act  = word.act;
    // the probe pointer only moves when the loop goes on
    ctrl.adv  = word.adv & ~hit_a & ~hit_b;
    ctrl.emit = word.emit;
    ctrl.res  = word.res;
  end

  assign busy = (upc_r != UPC_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/core/oaht_dpath.sv
// ----------------------------------------------------------------------------
// oaht_dpath
// Datapath: key and operation registers, digit-serial home/stride remainder,
// probe pointer and step, slot marks, key store and result registers.
// ----------------------------------------------------------------------------
module oaht_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oaht_pkg::ctrl_t                    ctrl,
  output oaht_pkg::stat_t                    stat,
  input  logic [oaht_pkg::FUNC_W-1:0]        in_func,
  input  logic [oaht_pkg::KEY_W-1:0]         in_key,
  input  logic                               cfg_we,
  input  logic [oaht_pkg::MODE_W-1:0]        cfg_wdata,
  output logic                               out_valid,
  output logic [oaht_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [oaht_pkg::SLOT_OUT_W-1:0]    out_slot_index
);
  import oaht_pkg::*;

  logic [MODE_W-1:0]     probe_mode_r;
  logic [MARK_W-1:0]     marks_r [TABLE_SIZE];
  logic                  out_valid_r;
  logic [KEY_W-1:0]      key_r;
  logic [FUNC_W-1:0]     func_r;
  slot_t                 hmod_r;
  slot_t                 smod_r;
  slot_t                 p_r;
  slot_t                 d_r;
  cnt_t                  cnt_r;
  logic                  walk_quad_r;
  logic [OUTCOME_W-1:0]  outcome_r;
  logic [SLOT_OUT_W-1:0] slot_r;

  logic [DIGITS*4-1:0]   key_pad;
  logic [DIG_W-1:0]      dsel;
  logic [3:0]            dig;
  logic [MARK_W-1:0]     mark_cur;
  logic [KEY_W-1:0]      rd_key;
  logic                  ram_we;

  oaht_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SIZE)
  ) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .waddr(p_r),
    .wdata(key_r),
    .raddr(p_r),
    .rdata(rd_key)
  );

  // most significant digit first
  assign key_pad  = (DIGITS*4)'(key_r);
  assign dsel     = DIG_W'(DIGITS - 1) - cnt_r[DIG_W-1:0];
  assign dig      = key_pad[{dsel, 2'b00} +: 4];
  assign mark_cur = marks_r[p_r];
  assign ram_we   = (ctrl.act == ACT_WRITE_KEY);

  always_comb begin
    stat.dig_last  = (cnt_r == CNT_W'(DIGITS - 1));
    stat.func_bad  = (func_r != FN_INSERT) && (func_r != FN_REMOVE) &&
                     (func_r != FN_SEARCH);
    stat.is_insert = (func_r == FN_INSERT);
    stat.match     = (mark_cur == MK_OCC) && (rd_key == key_r);
    stat.last      = (cnt_r == CNT_W'(TABLE_SIZE - 1));
    stat.free      = (mark_cur != MK_OCC);
    stat.stop      = stat.last || ((func_r == FN_SEARCH) && (mark_cur == MK_EMPTY));
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_mode_r <= PM_LINEAR;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        marks_r[i] <= MK_EMPTY;
      end
    end else begin
      out_valid_r <= ctrl.emit;
      if (cfg_we) begin
        probe_mode_r <= cfg_wdata;
      end
      if (ctrl.act == ACT_WRITE_KEY) begin
        marks_r[p_r] <= MK_OCC;
      end else if ((ctrl.act == ACT_MARK_DEL) && (func_r == FN_REMOVE)) begin
        marks_r[p_r] <= MK_DEL;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_LOAD: begin
        key_r  <= in_key;
        func_r <= in_func;
        cnt_r  <= '0;
        hmod_r <= '0;
        smod_r <= '0;
      end
      ACT_MOD_DIGIT: begin
        hmod_r <= mod_digit(hmod_r, dig, MOD_N);
        smod_r <= mod_digit(smod_r, dig, MOD_N1);
        cnt_r  <= cnt_r + cnt_t'(1);
      end
      ACT_SCAN_INIT: begin
        p_r         <= '0;
        d_r         <= ONE_SLOT;
        cnt_r       <= '0;
        walk_quad_r <= 1'b0;
      end
      ACT_PROBE_INIT: begin
        p_r         <= hmod_r;
        cnt_r       <= '0;
        walk_quad_r <= (probe_mode_r == PM_QUAD);
        case (probe_mode_r)
          PM_QUAD:   d_r <= FOUR_MOD;
          PM_DOUBLE: d_r <= smod_r + ONE_SLOT;
          default:   d_r <= ONE_SLOT;
        endcase
      end
      default: begin
      end
    endcase
    if (ctrl.adv) begin
      p_r   <= mod_add(p_r, d_r);
      cnt_r <= cnt_r + cnt_t'(1);
      // quadratic offsets grow by 6 each step
      if (walk_quad_r) begin
        d_r <= mod_add(d_r, SIX_MOD);
      end
    end
    if (ctrl.emit) begin
      outcome_r <= ctrl.res;
      slot_r    <= (ctrl.res == RES_OK) ? SLOT_OUT_W'(p_r) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_outcome    = outcome_r;
  assign out_slot_index = slot_r;

endmodule

### rtl/core/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressing hash table with linear, quadratic or double-hash probing,
// run by a microcoded sequencer over a single-port-per-cycle key store.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  input     start, busy, in_func, in_key            start & !busy
//  result    out_valid, out_outcome, out_slot_index  one-cycle strobe
//  config    cfg_we, cfg_wdata                       cfg_we, while idle
//
//  steps per beat, from accept to result strobe:
//    all ops first take the key apart mod 11 and mod 10, digit by digit
//    insert: a duplicate scan over all 11 slots, each read then checked,
//    then probes on marks alone until a free slot, or the table is full
//    remove / search: a read and a check per probe (registered key read)
//  reset: synchronous, all slots empty, probe mode linear; no clearing pass
//  busy stays high until the result strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [oaht_pkg::FUNC_W-1:0]        in_func,
  input  logic [oaht_pkg::KEY_W-1:0]         in_key,
  input  logic                               cfg_we,
  input  logic [oaht_pkg::MODE_W-1:0]        cfg_wdata,
  output logic                               out_valid,
  output logic [oaht_pkg::OUTCOME_W-1:0]     out_outcome,
  output logic [oaht_pkg::SLOT_OUT_W-1:0]    out_slot_index
);
  import oaht_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  oaht_useq u_useq (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  oaht_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_func       (in_func),
    .in_key        (in_key),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_outcome   (out_outcome),
    .out_slot_index(out_slot_index)
  );

endmodule

### rtl/core/oaht_checker.sv
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks on the hash table: result timing against busy and the
// shape of the result fields.
// ----------------------------------------------------------------------------
module oaht_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [oaht_pkg::OUTCOME_W-1:0]     out_outcome,
  input logic [oaht_pkg::SLOT_OUT_W-1:0]    out_slot_index
);
  import oaht_pkg::*;

  // an accepted beat raises busy in the cycle after
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // the result strobe comes as busy drops
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of an operation");

  // one result per beat, never two in a row
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome != RES_OK)) |-> (out_slot_index == '0))
    else $error("failed operation reports a nonzero slot");

  a_ok_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == RES_OK)) |-> (out_slot_index < TABLE_SIZE))
    else $error("reported slot beyond the table");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for open_addressing_hash_table. A scoreboard class
// mirrors the slot keys, slot marks and probe mode, predicts the reply to
// every accepted insert, remove, search and unused code, and compares each
// result strobe with the oldest prediction. Directed beats cover collisions,
// deleted slots, a full table and the unused function code. Random phases
// then run every probe mode, some of them with sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oaht_tb_pkg;
  import oaht_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0] PM_SPARE  = 2'd3;

  typedef struct packed {
    logic [OUTCOME_W-1:0]  outcome;
    logic [SLOT_OUT_W-1:0] slot;
  } reply_t;

  class oaht_scoreboard;
    logic [KEY_W-1:0]  slot_keys[TABLE_SIZE];
    logic [MARK_W-1:0] slot_marks[TABLE_SIZE];
    logic [MODE_W-1:0] probe_mode;
    reply_t            pending_replies[$];
    int unsigned       op_count[4];
    int unsigned       outcome_count[4];
    int unsigned       mismatches;

    function new();
      foreach (slot_marks[s]) begin
        slot_marks[s] = MK_EMPTY;
        slot_keys[s]  = '0;
      end
      foreach (op_count[i]) begin
        op_count[i]      = 0;
        outcome_count[i] = 0;
      end
      probe_mode = PM_LINEAR;
      mismatches = 0;
    endfunction

    function void set_mode(logic [MODE_W-1:0] mode);
      probe_mode = mode;
    endfunction

    // slot visited at a given probe step; the spare mode probes linearly
    function int unsigned probe_pos(logic [KEY_W-1:0] key, int unsigned step);
      int unsigned k;
      int unsigned home;
      int unsigned pos;
      k    = key;
      home = k % TABLE_SIZE;
      case (probe_mode)
        PM_QUAD:   pos = home + step + 3 * step * step;
        PM_DOUBLE: pos = home + step * (1 + k % (TABLE_SIZE - 1));
        default:   pos = home + step;
      endcase
      return pos % TABLE_SIZE;
    endfunction

    function reply_t apply_table_op(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
      reply_t      r;
      int unsigned p;
      logic        dup;
      r.outcome = RES_NOTFOUND;
      r.slot    = '0;
      dup       = 1'b0;
      case (func)
        FN_INSERT: begin
          // any occupied slot holding the key counts, wherever it sits
          for (int s = 0; s < TABLE_SIZE; s++) begin
            if (slot_marks[s] == MK_OCC && slot_keys[s] == key) dup = 1'b1;
          end
          if (dup) begin
            r.outcome = RES_DUP;
          end else begin
            r.outcome = RES_FULL;
            for (int s = 0; s < TABLE_SIZE; s++) begin
              p = probe_pos(key, s);
              if (slot_marks[p] != MK_OCC) begin
                slot_keys[p]  = key;
                slot_marks[p] = MK_OCC;
                r.outcome     = RES_OK;
                r.slot        = SLOT_OUT_W'(p);
                break;
              end
            end
          end
        end
        FN_REMOVE: begin
          for (int s = 0; s < TABLE_SIZE; s++) begin
            p = probe_pos(key, s);
            if (slot_marks[p] == MK_OCC && slot_keys[p] == key) begin
              slot_marks[p] = MK_DEL;
              r.outcome     = RES_OK;
              r.slot        = SLOT_OUT_W'(p);
              break;
            end
          end
        end
        FN_SEARCH: begin
          // deleted slots are walked past, an empty one ends the search
          for (int s = 0; s < TABLE_SIZE; s++) begin
            p = probe_pos(key, s);
            if (slot_marks[p] == MK_OCC && slot_keys[p] == key) begin
              r.outcome = RES_OK;
              r.slot    = SLOT_OUT_W'(p);
              break;
            end
            if (slot_marks[p] == MK_EMPTY) break;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_op(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
      op_count[func]++;
      pending_replies.push_back(apply_table_op(func, key));
    endfunction

    function void check_reply(logic [OUTCOME_W-1:0] outcome, logic [SLOT_OUT_W-1:0] slot);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: outcome %0d slot %0d", outcome, slot);
        return;
      end
      want = pending_replies.pop_front();
      outcome_count[want.outcome]++;
      if (outcome !== want.outcome || slot !== want.slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: outcome exp %0d got %0d, slot exp %0d got %0d",
                   want.outcome, outcome, want.slot, slot);
      end
    endfunction

    // picks a key that sits in an occupied slot; key is left alone if none
    function logic held_key(inout logic [KEY_W-1:0] key);
      int unsigned live[$];
      for (int s = 0; s < TABLE_SIZE; s++) begin
        if (slot_marks[s] == MK_OCC) live.push_back(s);
      end
      if (live.size() == 0) return 1'b0;
      key = slot_keys[live[$urandom_range(live.size() - 1)]];
      return 1'b1;
    endfunction
  endclass
endpackage

module tb;
  import oaht_pkg::*;
  import oaht_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int POOL_SIZE      = 20;
  localparam int PHASE_ITEMS    = 141;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [FUNC_W-1:0]     in_func;
  logic [KEY_W-1:0]      in_key;
  logic                  cfg_we;
  logic [MODE_W-1:0]     cfg_wdata;
  logic                  out_valid;
  logic [OUTCOME_W-1:0]  out_outcome;
  logic [SLOT_OUT_W-1:0] out_slot_index;

  oaht_scoreboard   sb;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int unsigned      idle_cycles;

  open_addressing_hash_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_key         (in_key),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_outcome    (out_outcome),
    .out_slot_index (out_slot_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_reply(out_outcome, out_slot_index);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[open_addressing_hash_table] ERROR");
      $finish;
    end
  end

  // hold the beat until the block takes it
  task automatic send_op(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
    start   <= 1'b1;
    in_func <= func;
    in_key  <= key;
    do @(posedge clk); while (busy);
    sb.note_op(func, key);
  endtask

  // long gaps so that start rises at any point of the block's busy window
  task automatic pause_sender(input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(60, 1);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_probe_mode(input logic [MODE_W-1:0] mode);
    start <= 1'b0;
    while (sb.pending_replies.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_mode(mode);
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    return KEY_W'($urandom);
  endfunction

  // mix of colliding keys, small keys, full-width keys and both extremes
  function automatic void refill_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      case (i % 3)
        0:       key_pool[i] = KEY_W'(TABLE_SIZE * $urandom_range(40) + i % 4);
        1:       key_pool[i] = any_key();
        default: key_pool[i] = KEY_W'($urandom_range(30));
      endcase
    end
  endfunction

  task automatic run_directed();
    logic [KEY_W-1:0] max_key;
    max_key = '1;
    send_op(FN_INSERT, '0);
    send_op(FN_INSERT, KEY_W'(TABLE_SIZE));      // same home slot as key zero
    send_op(FN_INSERT, max_key);
    send_op(FN_INSERT, '0);                      // duplicate
    send_op(FN_SEARCH, KEY_W'(TABLE_SIZE));
    send_op(FN_REMOVE, '0);
    send_op(FN_SEARCH, KEY_W'(TABLE_SIZE));      // walks past a deleted slot
    send_op(FN_SEARCH, '0);
    send_op(FN_REMOVE, '0);
    send_op(FN_UNUSED, KEY_W'(2 * TABLE_SIZE));
    send_op(FN_INSERT, KEY_W'(2 * TABLE_SIZE));  // reuses the deleted slot
    // eight more fill the table, the last one finds it full
    for (int i = 0; i < 9; i++) send_op(FN_INSERT, KEY_W'(TABLE_SIZE * (3 + i) + 5));
    send_op(FN_SEARCH, 31'h2AAA_AAAA);           // absent key, full walk
    send_op(FN_REMOVE, max_key);
    send_op(FN_INSERT, 31'h5555_5555);
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode, input int unsigned idle_pct,
                           input int unsigned count);
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    int unsigned       roll;
    write_probe_mode(mode);
    refill_pool();
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 42) func = FN_INSERT;
      else if (roll < 70) func = FN_REMOVE;
      else if (roll < 95) func = FN_SEARCH;
      else func = FN_UNUSED;
      key  = key_pool[$urandom_range(POOL_SIZE - 1)];
      roll = $urandom_range(99);
      case (func)
        FN_INSERT: if (roll < 15) key = any_key();
        FN_REMOVE: if (roll < 70) void'(sb.held_key(key));
        FN_SEARCH: begin
          if (roll < 50) void'(sb.held_key(key));
          else if (roll < 65) key = any_key();
        end
        default: ;
      endcase
      send_op(func, key);
      pause_sender(idle_pct);
    end
  endtask

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_func   <= FN_INSERT;
    in_key    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= PM_LINEAR;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    // the receiver cannot stall, so the phases idle only the sender, some not at all
    run_phase(PM_QUAD,   0,  PHASE_ITEMS);
    run_phase(PM_DOUBLE, 72, PHASE_ITEMS);
    run_phase(PM_SPARE,  0,  PHASE_ITEMS);
    run_phase(PM_LINEAR, 12, PHASE_ITEMS);
    run_phase(PM_DOUBLE, 0,  PHASE_ITEMS);
    run_phase(PM_SPARE,  72, PHASE_ITEMS);
    run_phase(PM_QUAD,   0,  PHASE_ITEMS);
    run_phase(PM_LINEAR, 12, PHASE_ITEMS);
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d inserts, %0d removes, %0d searches, %0d unused codes over all probe modes",
             sb.op_count[FN_INSERT], sb.op_count[FN_REMOVE], sb.op_count[FN_SEARCH],
             sb.op_count[FN_UNUSED]);
    $display("replies: %0d ok, %0d duplicate, %0d full, %0d not found; %0d mismatches",
             sb.outcome_count[RES_OK], sb.outcome_count[RES_DUP], sb.outcome_count[RES_FULL],
             sb.outcome_count[RES_NOTFOUND], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("[open_addressing_hash_table] OK");
    end else begin
      $display("[open_addressing_hash_table] ERROR");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/oaht_pkg.sv
rtl/core/oaht_ram.sv
rtl/core/oaht_useq.sv
rtl/core/oaht_dpath.sv
rtl/core/open_addressing_hash_table.sv
rtl/core/oaht_checker.sv
tb/tb.sv
